// ===== src/job_completion_statistics_assert.svh =====
// Assertion macros for the job completion statistics block.
// Used by the port checker; needs nothing else.
`ifndef JOB_COMPLETION_STATISTICS_ASSERT_SVH
`define JOB_COMPLETION_STATISTICS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define JCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("job_completion_statistics: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define JCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("job_completion_statistics: next-cycle check failed");

`endif

// ===== src/jcs_pkg.sv =====
// Shared types and constants for the job completion statistics block.
// No dependencies; used by the top level, the divider and the checker.
`default_nettype none

package jcs_pkg;

  localparam logic CMD_COMPLETE = 1'b0;
  localparam logic CMD_FINALISE = 1'b1;

  localparam logic [15:0] INTERVAL_LENGTH_RESET = 16'd60;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // divider iteration counts, one quotient bit per step
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] STEPS_32 = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_48 = 7'd48;
  localparam logic [STEP_W-1:0] STEPS_64 = 7'd64;

  typedef struct packed {
    logic        cmd;
    logic [31:0] clock_req;
    logic [31:0] arrival;
    logic [31:0] service;
  } in_t;

  typedef struct packed {
    logic [31:0] makespan;
    logic [31:0] avg_throughput;
    logic [31:0] min_throughput;
    logic [31:0] max_throughput;
    logic [31:0] avg_turnaround;
    logic [47:0] max_overhead;
    logic [47:0] avg_overhead;
  } out_t;

  // numerator is left aligned: its top steps bits are the dividend
  typedef struct packed {
    logic              start;
    logic [63:0]       num;
    logic [31:0]       den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic        rem_nz;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/jcs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on jcs_pkg for the request and response structs.
`default_nettype none

module jcs_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jcs_pkg::div_req_t req,
  output jcs_pkg::div_rsp_t      rsp
);

  logic                      busy;
  logic                      done;
  logic [jcs_pkg::STEP_W-1:0] cnt;
  logic [31:0]               rem;
  logic [63:0]               quo;
  logic [31:0]               den;

  logic [32:0] r_sh;
  logic [32:0] diff;
  logic        ge;

  assign r_sh = {rem, quo[63]};
  assign ge   = r_sh >= {1'b0, den};
  assign diff = r_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        quo <= {quo[62:0], ge};
        // partial remainder stays below the divisor, so 32 bits hold it
        rem <= ge ? diff[31:0] : r_sh[31:0];
        cnt <= cnt - 1'b1;
        if (cnt == jcs_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.quot   = quo;
  assign rsp.rem_nz = rem != 32'd0;

endmodule

`default_nettype wire

// ===== src/job_completion_statistics.sv =====
// Job completion statistics monitor. Takes one word at a time: a completion
// runs a 48-step overhead-ratio divide and then a 32-step interval divide,
// each issued in S_START and collected in S_WAIT, and then updates the
// statistics in S_UPDATE. A finalise runs a 32-step throughput divide and
// two 64-step averaging divides the same way, then loads its result into
// the output register in S_EMIT once that register is free. All divides
// run on one shared radix-2 divider that makes one quotient bit per cycle;
// a zero job time, a zero clock or an empty completion count skips the
// divides concerned.
// in_stall stays high until the word is done; a finished result waits in the
// output register while the next word is taken, and a finalise that finds the
// output register still stalled holds until it is taken.
// cfg_ready is always high; write interval_length only while idle.
`default_nettype none

module job_completion_statistics (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire jcs_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output jcs_pkg::out_t     out_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_WAIT   = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OP_RATIO = 3'd0,
    OP_IV    = 3'd1,
    OP_THR   = 3'd2,
    OP_TURN  = 3'd3,
    OP_OVR   = 3'd4
  } op_t;

  state_t state;
  op_t    op;

  logic [15:0] interval_length;

  // captured word
  logic [31:0] clk_r;
  logic [31:0] turn_r;
  logic [31:0] jt_r;

  // per-word results
  logic [47:0] ratio_r;
  logic [31:0] iv_r;
  logic [31:0] thr_r;
  logic [31:0] tavg_r;
  logic [47:0] oavg_r;

  // statistics
  logic [63:0] turnaround_total;
  logic [63:0] overhead_total;
  logic [47:0] overhead_peak;
  logic [31:0] completed_count;
  logic [31:0] current_interval;
  logic [31:0] interval_completions;
  logic [31:0] fewest_per_interval;
  logic        fewest_valid;
  logic [31:0] most_per_interval;

  jcs_pkg::div_req_t div_req;
  jcs_pkg::div_rsp_t div_rsp;

  jcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic        accept;
  logic        skip;
  logic [15:0] len;
  logic [31:0] in_turn;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign len       = (interval_length == 16'd0) ? 16'd1 : interval_length;
  assign in_turn   = (in_data.clock_req >= in_data.arrival) ?
                     in_data.clock_req - in_data.arrival : 32'd0;

  // pick the divide for the current step, or skip it
  always_comb begin
    div_req = '0;
    skip    = 1'b0;
    if (state == S_START) begin
      unique case (op)
        OP_RATIO: begin
          skip          = jt_r == 32'd0;
          div_req.num   = {turn_r, 32'd0};
          div_req.den   = jt_r;
          div_req.steps = jcs_pkg::STEPS_48;
        end
        OP_IV: begin
          skip          = clk_r == 32'd0;
          div_req.num   = {clk_r - 32'd1, 32'd0};
          div_req.den   = {16'd0, len};
          div_req.steps = jcs_pkg::STEPS_32;
        end
        OP_THR: begin
          skip          = completed_count == 32'd0;
          div_req.num   = {completed_count, 32'd0};
          div_req.den   = current_interval + 32'd1;
          div_req.steps = jcs_pkg::STEPS_32;
        end
        OP_TURN: begin
          div_req.num   = turnaround_total;
          div_req.den   = completed_count;
          div_req.steps = jcs_pkg::STEPS_64;
        end
        OP_OVR: begin
          div_req.num   = overhead_total;
          div_req.den   = completed_count;
          div_req.steps = jcs_pkg::STEPS_64;
        end
        default: begin
          skip = 1'b1;
        end
      endcase
      div_req.start = !skip;
    end
  end

  // rounded-up and saturated quotients
  logic [32:0] q_ceil;
  assign q_ceil = {1'b0, div_rsp.quot[31:0]} + {32'd0, div_rsp.rem_nz};

  // completion update
  logic [64:0] tt_sum;
  logic [64:0] ot_sum;
  logic        iv_ahead;
  logic [31:0] iv_gap;
  logic [31:0] ic_next;
  logic [31:0] fewest_next;
  logic [31:0] min_fin;

  assign tt_sum   = {1'b0, turnaround_total} + {33'd0, turn_r};
  assign ot_sum   = {1'b0, overhead_total} + {17'd0, ratio_r};
  assign iv_ahead = iv_r > current_interval;
  assign iv_gap   = iv_r - current_interval;

  always_comb begin
    fewest_next = fewest_per_interval;
    if (iv_ahead) begin
      ic_next = 32'd1;
      // a skipped interval had no completions
      if (iv_gap > 32'd1) begin
        fewest_next = 32'd0;
      end else if (!fewest_valid || interval_completions < fewest_per_interval) begin
        fewest_next = interval_completions;
      end
    end else begin
      ic_next = (interval_completions == jcs_pkg::MAX32) ?
                interval_completions : interval_completions + 32'd1;
    end
  end

  assign min_fin = (!fewest_valid || interval_completions < fewest_per_interval) ?
                   interval_completions : fewest_per_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      op                   <= OP_RATIO;
      interval_length      <= jcs_pkg::INTERVAL_LENGTH_RESET;
      turnaround_total     <= '0;
      overhead_total       <= '0;
      overhead_peak        <= '0;
      completed_count      <= '0;
      current_interval     <= '0;
      interval_completions <= '0;
      fewest_per_interval  <= '0;
      fewest_valid         <= 1'b0;
      most_per_interval    <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval_length <= cfg_data;
      end
      // drop a taken word; S_EMIT refills the register itself
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            clk_r  <= in_data.clock_req;
            turn_r <= in_turn;
            jt_r   <= in_data.service;
            op     <= (in_data.cmd == jcs_pkg::CMD_FINALISE) ? OP_THR : OP_RATIO;
            state  <= S_START;
          end
        end
        S_START: begin
          if (skip) begin
            unique case (op)
              OP_RATIO: begin
                ratio_r <= jcs_pkg::MAX48;
                op      <= OP_IV;
              end
              OP_IV: begin
                iv_r  <= 32'd0;
                state <= S_UPDATE;
              end
              default: begin
                // no completions: all averages are zero
                thr_r  <= 32'd0;
                tavg_r <= 32'd0;
                oavg_r <= 48'd0;
                state  <= S_EMIT;
              end
            endcase
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            unique case (op)
              OP_RATIO: begin
                ratio_r <= div_rsp.quot[47:0];
                op      <= OP_IV;
                state   <= S_START;
              end
              OP_IV: begin
                iv_r  <= div_rsp.quot[31:0];
                state <= S_UPDATE;
              end
              OP_THR: begin
                thr_r <= q_ceil[31:0];
                op    <= OP_TURN;
                state <= S_START;
              end
              OP_TURN: begin
                tavg_r <= (div_rsp.quot[63:32] != 32'd0 || q_ceil[32]) ?
                          jcs_pkg::MAX32 : q_ceil[31:0];
                op     <= OP_OVR;
                state  <= S_START;
              end
              default: begin
                oavg_r <= (div_rsp.quot[63:48] != 16'd0) ?
                          jcs_pkg::MAX48 : div_rsp.quot[47:0];
                state  <= S_EMIT;
              end
            endcase
          end
        end
        S_UPDATE: begin
          turnaround_total <= tt_sum[64] ? jcs_pkg::MAX64 : tt_sum[63:0];
          overhead_total   <= ot_sum[64] ? jcs_pkg::MAX64 : ot_sum[63:0];
          completed_count  <= (completed_count == jcs_pkg::MAX32) ?
                              completed_count : completed_count + 32'd1;
          if (ratio_r > overhead_peak) begin
            overhead_peak <= ratio_r;
          end
          if (iv_ahead) begin
            current_interval <= iv_r;
            fewest_valid     <= 1'b1;
          end
          fewest_per_interval  <= fewest_next;
          interval_completions <= ic_next;
          if (ic_next > most_per_interval) begin
            most_per_interval <= ic_next;
          end
          state <= S_IDLE;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.makespan       <= clk_r;
            out_data.avg_throughput <= thr_r;
            out_data.min_throughput <= min_fin;
            out_data.max_throughput <= most_per_interval;
            out_data.avg_turnaround <= tavg_r;
            out_data.max_overhead   <= overhead_peak;
            out_data.avg_overhead   <= oavg_r;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/jcs_checker.sv =====
// Port-level checker for job_completion_statistics, bound to the top level.
// Depends on jcs_pkg and on job_completion_statistics_assert.svh.
`default_nettype none

`include "job_completion_statistics_assert.svh"

module jcs_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire jcs_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire jcs_pkg::out_t out_data
);

  // a stalled result word holds
  `JCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // one word at a time: busy right after a word is taken
  `JCS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // a completion word never produces a result
  `JCS_ASSERT_NEXT(a_completion_silent, clk, rst, in_valid && !in_stall && in_data.cmd == jcs_pkg::CMD_COMPLETE, !$rose(out_valid))

  // fewest per interval never exceeds most per interval
  `JCS_ASSERT_NOW(a_min_le_max, clk, rst, out_valid, out_data.min_throughput <= out_data.max_throughput)

endmodule

bind job_completion_statistics jcs_checker u_jcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== dv/job_completion_statistics_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the job completion statistics block: keeps its own copy of
// the statistics counters, predicts every finalise word and compares it.
// Depends on jcs_pkg for the word types, command codes and saturation limits.
module job_completion_statistics_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  jcs_pkg::in_t   in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  jcs_pkg::out_t  out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [15:0]    cfg_data,
  output int             fail_count,
  output int             pending
);
  import jcs_pkg::*;

  logic [15:0] iv_len;
  logic [63:0] turn_sum;
  logic [63:0] ratio_sum;
  logic [47:0] ratio_peak;
  logic [31:0] done_cnt;
  logic [31:0] cur_iv;
  logic [31:0] iv_done;
  logic [31:0] fewest;
  logic        fewest_ok;
  logic [31:0] most;
  out_t        stats_due[$];

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAX64 : s[63:0];
  endfunction

  function automatic logic [31:0] bump32(input logic [31:0] a);
    return (a == MAX32) ? MAX32 : a + 32'd1;
  endfunction

  function automatic logic [63:0] ceil_quot(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    if (den == 64'd0) return 64'd0;
    q = num / den;
    if (num % den != 64'd0) q = q + 64'd1;
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t checker: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic absorb_completion(input in_t w);
    logic [63:0] turn;
    logic [63:0] ratio;
    logic [63:0] len;
    logic [63:0] iv;
    turn = (w.clock_req >= w.arrival) ? {32'd0, w.clock_req - w.arrival} : 64'd0;
    ratio = (w.service == 32'd0) ? {16'd0, MAX48} : (turn << 16) / {32'd0, w.service};
    if (ratio > {16'd0, MAX48}) ratio = {16'd0, MAX48};
    len = (iv_len == 16'd0) ? 64'd1 : {48'd0, iv_len};
    iv = (w.clock_req == 32'd0) ? 64'd0 : ({32'd0, w.clock_req} - 64'd1) / len;

    turn_sum = sat_add(turn_sum, turn);
    ratio_sum = sat_add(ratio_sum, ratio);
    done_cnt = bump32(done_cnt);
    if (ratio > {16'd0, ratio_peak}) ratio_peak = ratio[47:0];

    if (iv > {32'd0, cur_iv}) begin
      // a whole interval went by with no completion
      if (iv - {32'd0, cur_iv} > 64'd1) begin
        fewest = 32'd0;
        fewest_ok = 1'b1;
      end
      cur_iv = iv[31:0];
      if (!fewest_ok || iv_done < fewest) begin
        fewest = iv_done;
        fewest_ok = 1'b1;
      end
      iv_done = 32'd1;
    end else begin
      // same interval, or the clock went back
      iv_done = bump32(iv_done);
    end
    if (iv_done > most) most = iv_done;
  endtask

  function automatic out_t stats_snapshot(input logic [31:0] clock_now);
    out_t        r;
    logic [63:0] q;
    r.makespan = clock_now;
    q = ceil_quot({32'd0, done_cnt}, {32'd0, cur_iv} + 64'd1);
    r.avg_throughput = (q > {32'd0, MAX32}) ? MAX32 : q[31:0];
    r.min_throughput = (!fewest_ok || iv_done < fewest) ? iv_done : fewest;
    r.max_throughput = most;
    q = ceil_quot(turn_sum, {32'd0, done_cnt});
    r.avg_turnaround = (q > {32'd0, MAX32}) ? MAX32 : q[31:0];
    r.max_overhead = ratio_peak;
    q = (done_cnt == 32'd0) ? 64'd0 : ratio_sum / {32'd0, done_cnt};
    r.avg_overhead = (q > {16'd0, MAX48}) ? MAX48 : q[47:0];
    return r;
  endfunction

  task automatic check_stats(input out_t got);
    out_t want;
    if (stats_due.size() == 0) begin
      report_mismatch("result with nothing due, makespan", {32'd0, got.makespan}, 64'd0);
    end else begin
      want = stats_due.pop_front();
      if (got.makespan !== want.makespan)
        report_mismatch("makespan", {32'd0, got.makespan}, {32'd0, want.makespan});
      if (got.avg_throughput !== want.avg_throughput)
        report_mismatch("avg_throughput", {32'd0, got.avg_throughput},
                        {32'd0, want.avg_throughput});
      if (got.min_throughput !== want.min_throughput)
        report_mismatch("min_throughput", {32'd0, got.min_throughput},
                        {32'd0, want.min_throughput});
      if (got.max_throughput !== want.max_throughput)
        report_mismatch("max_throughput", {32'd0, got.max_throughput},
                        {32'd0, want.max_throughput});
      if (got.avg_turnaround !== want.avg_turnaround)
        report_mismatch("avg_turnaround", {32'd0, got.avg_turnaround},
                        {32'd0, want.avg_turnaround});
      if (got.max_overhead !== want.max_overhead)
        report_mismatch("max_overhead", {16'd0, got.max_overhead},
                        {16'd0, want.max_overhead});
      if (got.avg_overhead !== want.avg_overhead)
        report_mismatch("avg_overhead", {16'd0, got.avg_overhead},
                        {16'd0, want.avg_overhead});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      iv_len = INTERVAL_LENGTH_RESET;
      turn_sum = 64'd0;
      ratio_sum = 64'd0;
      ratio_peak = 48'd0;
      done_cnt = 32'd0;
      cur_iv = 32'd0;
      iv_done = 32'd0;
      fewest = 32'd0;
      fewest_ok = 1'b0;
      most = 32'd0;
      stats_due.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) check_stats(out_data);
      if (cfg_valid && cfg_ready) iv_len = cfg_data;
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_FINALISE) stats_due.push_back(stats_snapshot(in_data.clock_req));
        else absorb_completion(in_data);
      end
      pending <= stats_due.size();
    end
  end

endmodule

// ===== dv/job_completion_statistics_tb.sv =====
`timescale 1ns / 1ps
// Top of the job completion statistics testbench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Needs jcs_pkg, the block and the checker.
module job_completion_statistics_tb;
  import jcs_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 250;
  localparam int PHASE_WORDS = 65;
  localparam int NOISE_WORDS = 30;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  int              idle_cycles = 0;
  int              stall_run = 0;
  int              burst_left = 0;
  logic [15:0]     cur_len = INTERVAL_LENGTH_RESET;
  longint unsigned top_iv = 0;
  logic [15:0]     phase_len [8] = '{16'd1, 16'd7, 16'd0, 16'd65535,
                                     16'd3, 16'd60, 16'd1000, 16'd2};

  job_completion_statistics i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  job_completion_statistics_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: free-flowing stretches, long stalls and choppy runs
  always @(posedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b0;
          stall_run <= $urandom_range(20, 400);
        end
        1: begin
          out_stall <= 1'b1;
          stall_run <= $urandom_range(1, 60);
        end
        default: begin
          out_stall <= 1'($urandom_range(0, 1));
          stall_run <= $urandom_range(0, 3);
        end
      endcase
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("job_completion_statistics_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one word, hold it until taken, then either keep the burst going
  // or drop valid for a random gap
  task automatic put_word(input in_t w);
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic send_job(input logic [31:0] clock_now, input logic [31:0] arrival,
                          input logic [31:0] service);
    in_t             w;
    longint unsigned len_eff;
    longint unsigned iv;
    len_eff = (cur_len == 16'd0) ? 1 : cur_len;
    iv = (clock_now == 32'd0) ? 0 : (longint'(clock_now) - 1) / len_eff;
    if (iv > top_iv) top_iv = iv;
    w.cmd = CMD_COMPLETE;
    w.clock_req = clock_now;
    w.arrival = arrival;
    w.service = service;
    put_word(w);
  endtask

  task automatic send_finalise(input logic [31:0] clock_now);
    in_t w;
    w.cmd = CMD_FINALISE;
    w.clock_req = clock_now;
    w.arrival = $urandom;
    w.service = $urandom;
    put_word(w);
  endtask

  // hold the sender until every due result is back, then let the block settle
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_interval(input logic [15:0] len);
    cfg_data <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_len = len;
  endtask

  initial begin
    longint unsigned len_eff;
    longint unsigned now_tick;
    longint unsigned clk_val;
    longint unsigned start;
    logic [31:0]     arr;
    logic [31:0]     jt;
    int              pick;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset interval length of 60
    send_finalise(32'd1);                     // nothing completed yet
    send_job(32'd0, 32'd0, 32'd1);            // zero clock
    send_job(32'd10, 32'd20, 32'd5);          // arrival after clock
    send_job(32'd30, 32'd0, 32'd0);           // zero job time
    send_job(32'd40, MAX32, MAX32);
    send_finalise(MAX32);
    send_job(32'd70, 32'd5, 32'd1);           // next interval
    send_job(32'd300, 32'd0, 32'd3);          // skips intervals
    send_job(32'd100, 32'd100, 32'd7);        // clock moves back
    send_finalise(32'd0);
    send_job(32'd301, 32'd1, MAX32);
    send_job(32'd360, 32'd0, 32'd2);
    send_job(32'd361, 32'd300, 32'd1);
    send_finalise(32'd400);
    send_finalise(32'd400);                   // finalise repeats
    now_tick = 361;

    for (int p = 0; p < 8; p++) begin
      drain_results;
      set_interval(phase_len[p]);
      len_eff = (cur_len == 16'd0) ? 1 : cur_len;
      // start past the highest interval seen so far, if the clock allows
      start = (top_iv + 1) * len_eff + 1;
      if (start <= MAX32) now_tick = start;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          send_finalise(now_tick[31:0]);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 55) now_tick += $urandom_range(0, 32'(len_eff / 3));
          else if (pick < 85) now_tick += $urandom_range(32'(len_eff / 2), 32'(len_eff));
          else if (pick < 92) now_tick += $urandom_range(32'(2 * len_eff), 32'(4 * len_eff));
          if (now_tick > MAX32) now_tick = MAX32;
          clk_val = now_tick;
          if (pick >= 92)
            clk_val = now_tick - $urandom_range(0, 32'((now_tick < 3 * len_eff) ? now_tick
                                                                                : 3 * len_eff));

          pick = $urandom_range(0, 99);
          if (pick < 60)
            arr = (clk_val > 2000) ? 32'(clk_val - $urandom_range(0, 2000))
                                   : $urandom_range(0, 32'(clk_val));
          else if (pick < 72) arr = clk_val[31:0];
          else if (pick < 82) arr = 32'd0;
          else if (pick < 95) arr = $urandom;
          else arr = 32'(clk_val + $urandom_range(1, 50));

          pick = $urandom_range(0, 99);
          if (pick < 50) jt = $urandom_range(1, 100);
          else if (pick < 75) jt = $urandom_range(1, 65536);
          else if (pick < 90) jt = $urandom;
          else if (pick < 94) jt = 32'd1;
          else if (pick < 97) jt = MAX32;
          else jt = 32'd0;

          send_job(clk_val[31:0], arr, jt);
        end
      end
    end

    // noise: full-range clocks last, since they pull the interval far ahead
    drain_results;
    send_job(MAX32, 32'd0, 32'd1);
    send_job(MAX32, MAX32, MAX32);
    send_finalise(MAX32);
    for (int k = 0; k < NOISE_WORDS; k++) begin
      if ($urandom_range(0, 1) == 1) send_finalise($urandom);
      else send_job($urandom, $urandom, $urandom);
    end

    drain_results;
    if (fail_count == 0) begin
      $display("job_completion_statistics_tb: PASS");
    end else begin
      $display("job_completion_statistics_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/jcs_pkg.sv
src/jcs_div.sv
src/job_completion_statistics.sv
src/jcs_checker.sv
dv/job_completion_statistics_checker.sv
dv/job_completion_statistics_tb.sv
